@@ sv/integer_square_root_floor_defines.svh @@
// Assertion macros for the port checker file of the square root block.
// Depends on nothing; take in with `include.
`ifndef INTEGER_SQUARE_ROOT_FLOOR_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_FLOOR_DEFINES_SVH

// Property checked only while out of reset.
`define ISRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ISRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/isrf_pkg.sv @@
// Widths and types for the pipelined integer square root.
// No dependencies; used by the top level and its checker.
package isrf_pkg;

  localparam int INPUT_WIDTH = 31;
  localparam int ROOT_BITS   = (INPUT_WIDTH + 1) / 2;
  localparam int RAD_W       = 2 * ROOT_BITS;
  localparam int REM_W       = ROOT_BITS + 2;
  localparam int ROOT_W      = 16;
  localparam int ROOT_EXT_W  = (ROOT_BITS > ROOT_W) ? ROOT_BITS : ROOT_W;

  typedef logic [RAD_W-1:0]     rad_t;
  typedef logic [ROOT_BITS-1:0] root_t;
  typedef logic [REM_W-1:0]     rem_t;

endpackage

@@ sv/integer_square_root_floor.sv @@
// Floor square root of an unsigned radicand, one root bit per pipeline stage.
// Depends on isrf_pkg.
//
//  channel    valid             ready             payload
//  input      radicand_valid_i  radicand_ready_o  radicand_i[INPUT_WIDTH-1:0]
//  output     root_valid_o      root_ready_i      root_o[15:0]
//
// There are ROOT_BITS stages (16 for a 31-bit radicand), one per root bit, each a
// single remainder subtract and compare. One item enters per cycle unless stalled.
// Reset clears the stage valid bits only. A stall holds each full stage when every
// stage after it is full and the output is stalled; an empty stage keeps filling.
module integer_square_root_floor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [isrf_pkg::INPUT_WIDTH-1:0]   radicand_i,
  input  logic                               radicand_valid_i,
  output logic                               radicand_ready_o,
  output logic [isrf_pkg::ROOT_W-1:0]        root_o,
  output logic                               root_valid_o,
  input  logic                               root_ready_i
);

  localparam int N = isrf_pkg::ROOT_BITS;

  isrf_pkg::rad_t  st_x   [N];
  isrf_pkg::rem_t  st_rem [N];
  isrf_pkg::root_t st_q   [N];
  logic            st_v   [N];
  logic            rdy    [N];

  isrf_pkg::rad_t  x_q    [N];
  isrf_pkg::rem_t  rem_q  [N];
  isrf_pkg::root_t q_q    [N];
  logic            valid_q[N];

  logic [isrf_pkg::ROOT_EXT_W-1:0] root_ext;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [isrf_pkg::REM_W+1:0] rem_sh;
    logic [isrf_pkg::REM_W+1:0] trial;
    logic [isrf_pkg::REM_W+1:0] diff;
    logic                       ge;
    isrf_pkg::rem_t             rem_d;
    isrf_pkg::root_t            q_d;
    isrf_pkg::rad_t             x_d;

    if (k == 0) begin : g_head
      assign st_x[k]   = isrf_pkg::RAD_W'(radicand_i);
      assign st_rem[k] = '0;
      assign st_q[k]   = '0;
      assign st_v[k]   = radicand_valid_i;
    end else begin : g_body
      assign st_x[k]   = x_q[k-1];
      assign st_rem[k] = rem_q[k-1];
      assign st_q[k]   = q_q[k-1];
      assign st_v[k]   = valid_q[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign rdy[k] = !valid_q[k] || root_ready_i;
    end else begin : g_mid
      assign rdy[k] = !valid_q[k] || rdy[k+1];
    end

    // Bring down the next two radicand bits and try root bit one.
    always_comb begin
      rem_sh = {st_rem[k], st_x[k][isrf_pkg::RAD_W-1 -: 2]};
      trial  = (isrf_pkg::REM_W + 2)'({st_q[k], 2'b01});
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
      rem_d  = ge ? isrf_pkg::REM_W'(diff) : isrf_pkg::REM_W'(rem_sh);
      q_d    = isrf_pkg::ROOT_BITS'({st_q[k], ge});
      x_d    = st_x[k] << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= st_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        x_q[k]   <= x_d;
        rem_q[k] <= rem_d;
        q_q[k]   <= q_d;
      end
    end
  end

  assign root_ext         = isrf_pkg::ROOT_EXT_W'(q_q[N-1]);
  assign root_o           = root_ext[isrf_pkg::ROOT_W-1:0];
  assign root_valid_o     = valid_q[N-1];
  assign radicand_ready_o = rdy[0];

  // Remainder and radicand bits of the last stage feed nothing further.
  logic unused_tail;
  assign unused_tail = ^{x_q[N-1], rem_q[N-1]};

endmodule

@@ sv/isrf_checker.sv @@
// Port-level checks for integer_square_root_floor, bound to every instance.
// Depends on isrf_pkg and integer_square_root_floor_defines.svh.
`include "integer_square_root_floor_defines.svh"

module isrf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              radicand_valid_i,
  input logic                              radicand_ready_o,
  input logic [isrf_pkg::ROOT_W-1:0]       root_o,
  input logic                              root_valid_o,
  input logic                              root_ready_i
);

  `ISRF_ASSERT(a_out_valid_hold, clk_i, rst_ni, root_valid_o && !root_ready_i |=> root_valid_o, "root valid dropped while stalled")
  `ISRF_ASSERT(a_out_root_hold, clk_i, rst_ni, root_valid_o && !root_ready_i |=> $stable(root_o), "root changed while stalled")
  `ISRF_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !root_valid_o, "root valid during reset")
  `ISRF_ASSERT(a_ready_when_drained, clk_i, rst_ni, !root_valid_o || root_ready_i |-> radicand_ready_o, "input stalled with output free")

endmodule

bind integer_square_root_floor isrf_checker u_isrf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .radicand_valid_i (radicand_valid_i),
  .radicand_ready_o (radicand_ready_o),
  .root_o           (root_o),
  .root_valid_o     (root_valid_o),
  .root_ready_i     (root_ready_i)
);

@@ tb/isrf_root_checker.sv @@
// Result checker for the integer square root block: watches both channels,
// predicts each root and compares it with what the block returns.
// Depends on isrf_pkg.
`timescale 1ns / 1ps

module isrf_root_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [isrf_pkg::INPUT_WIDTH-1:0] radicand_i,
  input  logic                             radicand_valid_i,
  input  logic                             radicand_ready_o,
  input  logic [isrf_pkg::ROOT_W-1:0]      root_o,
  input  logic                             root_valid_o,
  input  logic                             root_ready_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               radicands_seen_o,
  output int                               roots_checked_o
);

  localparam int REPORT_LIMIT = 10;

  logic [isrf_pkg::ROOT_W-1:0] expected_roots[$];
  int                          mismatch_count;

  // Bit-serial floor root, most significant trial bit first.
  function automatic logic [isrf_pkg::ROOT_W-1:0] floor_root(
    logic [isrf_pkg::INPUT_WIDTH-1:0] radicand
  );
    logic [63:0] value;
    logic [63:0] root;
    logic [63:0] trial;
    value = 64'(radicand);
    root  = '0;
    for (int b = isrf_pkg::ROOT_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root[isrf_pkg::ROOT_W-1:0];
  endfunction

  initial begin
    fail_count_o     = 0;
    radicands_seen_o = 0;
    roots_checked_o  = 0;
    mismatch_count   = 0;
  end

  assign pending_o = expected_roots.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Check the result first so an item entering at the same edge cannot mask it.
      if (root_valid_o && root_ready_i) begin
        roots_checked_o <= roots_checked_o + 1;
        if (expected_roots.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (mismatch_count < REPORT_LIMIT)
            $display("[%0t] unexpected root item: root=%0d", $realtime, root_o);
          mismatch_count++;
        end else begin
          if (root_o !== expected_roots[0]) begin
            fail_count_o <= fail_count_o + 1;
            if (mismatch_count < REPORT_LIMIT)
              $display("[%0t] root mismatch: expected %0d, actual %0d",
                       $realtime, expected_roots[0], root_o);
            mismatch_count++;
          end
          void'(expected_roots.pop_front());
        end
      end
      if (radicand_valid_i && radicand_ready_o) begin
        expected_roots.push_back(floor_root(radicand_i));
        radicands_seen_o <= radicands_seen_o + 1;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for integer_square_root_floor: drives radicands with random
// gaps, stalls the root channel and reports the verdict from isrf_root_checker.
// Depends on isrf_pkg, integer_square_root_floor and isrf_root_checker.
`timescale 1ns / 1ps

module tb;

  localparam int          RANDOM_ITEMS = 1850;
  localparam int          PHASE_LEN    = 50;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 4 * isrf_pkg::ROOT_BITS;
  localparam logic [63:0] RAD_MAX      = (64'd1 << isrf_pkg::INPUT_WIDTH) - 1;
  localparam logic [63:0] TOP_ROOT     = 64'd46340;

  logic                             clk_i;
  logic                             rst_ni = 1'b1;
  logic [isrf_pkg::INPUT_WIDTH-1:0] radicand_i = '0;
  logic                             radicand_valid_i = 1'b0;
  logic                             radicand_ready_o;
  logic [isrf_pkg::ROOT_W-1:0]      root_o;
  logic                             root_valid_o;
  logic                             root_ready_i = 1'b0;

  int fail_count;
  int pending;
  int radicands_seen;
  int roots_checked;

  int cycle_count = 0;
  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;
  int stall_left  = 0;

  integer_square_root_floor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .radicand_i       (radicand_i),
    .radicand_valid_i (radicand_valid_i),
    .radicand_ready_o (radicand_ready_o),
    .root_o           (root_o),
    .root_valid_o     (root_valid_o),
    .root_ready_i     (root_ready_i)
  );

  isrf_root_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .radicand_i       (radicand_i),
    .radicand_valid_i (radicand_valid_i),
    .radicand_ready_o (radicand_ready_o),
    .root_o           (root_o),
    .root_valid_o     (root_valid_o),
    .root_ready_i     (root_ready_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .radicands_seen_o (radicands_seen),
    .roots_checked_o  (roots_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d roots still pending", cycle_count, pending);
      $display("FAIL integer_square_root_floor");
      $finish;
    end
  end

  // Drop ready for a random number of cycles after each root item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (root_valid_o && root_ready_i)
        stall_left = stalls_on ? $urandom_range(0, 6) : 0;
      else if (stall_left > 0)
        stall_left--;
      root_ready_i <= (stall_left == 0);
    end
  end

  // Hold valid and payload until the item is taken.
  task automatic send_radicand(logic [63:0] value);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      radicand_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    radicand_i       <= value[isrf_pkg::INPUT_WIDTH-1:0];
    radicand_valid_i <= 1'b1;
    do @(posedge clk_i); while (!radicand_ready_o);
  endtask

  function automatic logic [63:0] clamp_radicand(longint value);
    if (value < 0) return 64'd0;
    if (value > longint'(RAD_MAX)) return RAD_MAX;
    return 64'(value);
  endfunction

  function automatic logic [63:0] random_radicand();
    logic [63:0] r;
    int          kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        return {$urandom, $urandom} & RAD_MAX;
      end
      4, 5, 6: begin
        // Exact square or a neighbor of one.
        r = 64'($urandom_range(0, int'(TOP_ROOT)));
        return clamp_radicand(longint'(r * r) + longint'($urandom_range(0, 2)) - 1);
      end
      7: begin
        return 64'($urandom_range(0, 300));
      end
      8: begin
        return RAD_MAX - 64'($urandom_range(0, 200000));
      end
      default: begin
        // Single power of two or a run of ones.
        r = 64'd1 << $urandom_range(0, isrf_pkg::INPUT_WIDTH - 1);
        return $urandom_range(0, 1) ? r : ((r << 1) - 1) & RAD_MAX;
      end
    endcase
  endfunction

  initial begin
    logic [63:0] directed[$];

    directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd8, 64'd9, 64'd15,
                 64'd16, 64'd24, 64'd25, 64'd255, 64'd256,
                 (64'd1 << 30) - 1, 64'd1 << 30, 64'h5555_5555 & RAD_MAX,
                 64'h2AAA_AAAA & RAD_MAX, 64'd46339 * 64'd46339, TOP_ROOT * TOP_ROOT - 1,
                 TOP_ROOT * TOP_ROOT, TOP_ROOT * TOP_ROOT + 1, RAD_MAX - 1, RAD_MAX};

    // Assert reset after time zero so the reset edge is seen before the first clock.
    #1 rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_radicand(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch idling per phase, keeping some stretches at full rate.
      if (n % PHASE_LEN == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_radicand(random_radicand());
    end
    radicand_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d radicands: edges, exact squares and neighbors, powers of two, random",
             radicands_seen);
    $display("values; %0d roots checked under random gaps and stalls, %0d failures.",
             roots_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS integer_square_root_floor");
    end else begin
      $display("FAIL integer_square_root_floor");
    end
    $finish;
  end

endmodule
